/* src/rgbhsv_pkg.sv */
// ----------------------------------------------------------------------------
// rgbhsv_pkg
// Shared types, constants and width helpers for the rgb to hsv converter.
// ----------------------------------------------------------------------------
package rgbhsv_pkg;

	// degrees in one hue sector and in the full circle
	localparam int HUE_SIXTY  = 60;
	localparam int HUE_CIRCLE = 360;

	// at most this many long-division steps in each divider stage
	localparam int DIV_STEPS = 6;

	// which channel holds the maximum
	typedef enum logic [1:0] {
		SECTOR_RED,
		SECTOR_GREEN,
		SECTOR_BLUE
	} hue_sector_t;

	// bits needed for a hue in 0 .. 360 * 2^hf - 1
	function automatic int hue_width(input int hf);
		return $clog2(HUE_CIRCLE * (2 ** hf));
	endfunction

endpackage

/* src/rgbhsv_if.sv */
// ----------------------------------------------------------------------------
// rgbhsv_if
// Valid/ready stream interfaces for rgb pixel words and hsv result words.
// ----------------------------------------------------------------------------

// rgb pixel word
interface rgbhsv_in_if #(
	parameter int CHANNEL_BITS = 8
) ();
	logic                    valid;
	logic                    ready;
	logic [CHANNEL_BITS-1:0] red_in;
	logic [CHANNEL_BITS-1:0] green_in;
	logic [CHANNEL_BITS-1:0] blue_in;

	modport source (output valid, red_in, green_in, blue_in, input ready);
	modport sink   (input valid, red_in, green_in, blue_in, output ready);
endinterface

// hsv result word
interface rgbhsv_out_if import rgbhsv_pkg::*; #(
	parameter int CHANNEL_BITS      = 8,
	parameter int HUE_FRACTION_BITS = 6,
	parameter int SATURATION_BITS   = 16
) ();
	localparam int HUE_W = hue_width(HUE_FRACTION_BITS);

	logic                       valid;
	logic                       ready;
	logic [HUE_W-1:0]           hue_out;
	logic                       hue_defined;
	logic [SATURATION_BITS-1:0] saturation_out;
	logic [CHANNEL_BITS-1:0]    value_out;

	modport source (output valid, hue_out, hue_defined, saturation_out, value_out,
		input ready);
	modport sink   (input valid, hue_out, hue_defined, saturation_out, value_out,
		output ready);
endinterface

/* src/rgb_to_hsv_converter.sv */
// ----------------------------------------------------------------------------
// rgb_to_hsv_converter
// Streams rgb pixels into hue, saturation and value through a deep pipeline
// with two pipelined dividers running side by side.
// ----------------------------------------------------------------------------
//
//  port   dir   word                                         handshake
//  -----  ----  -------------------------------------------  -----------
//  pix    in    red_in, green_in, blue_in                    valid/ready
//  hsv    out   hue_out, hue_defined, saturation_out,        valid/ready
//               value_out
//
// one pixel per clock sustained while the hsv side is ready; the number of divider
// stages is set by the wider divider dividend at DIV_STEPS bits a stage.
// reset clears only the stage valid bits; data registers are not reset.
// every stage holds while its successor is full and stalled, and an empty
// stage always loads, so bubbles close up and a stall drops nothing.
//
module rgb_to_hsv_converter import rgbhsv_pkg::*; #(
	parameter int CHANNEL_BITS      = 8,
	parameter int HUE_FRACTION_BITS = 6,
	parameter int SATURATION_BITS   = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	rgbhsv_in_if.sink   pix,
	rgbhsv_out_if.source hsv
);

	localparam int CB         = CHANNEL_BITS;
	localparam int SB         = SATURATION_BITS;
	localparam int HUE_W      = hue_width(HUE_FRACTION_BITS);
	localparam int HUE_UNIT   = HUE_SIXTY * (2 ** HUE_FRACTION_BITS);
	localparam int HUE_FULL   = HUE_CIRCLE * (2 ** HUE_FRACTION_BITS);
	localparam int QH_W       = $clog2(HUE_UNIT + 1);
	localparam int SN_W       = CB + SB;
	localparam int HN_W       = CB + QH_W;
	localparam int DIV_NUM_W  = (SN_W > HN_W) ? SN_W : HN_W;
	localparam int DIV_STAGES = (DIV_NUM_W + DIV_STEPS - 1) / DIV_STEPS;
	localparam int NSTG       = DIV_STAGES + 3;
	localparam int LAST_DIV   = DIV_STAGES + 1;

	// stage valid bits and load enables
	logic [NSTG-1:0] vld_q;
	logic [NSTG-1:0] adv;

	// stage 1: max, min, sector and signed difference
	logic [CB-1:0] mx_s1, delta_s1, absd_s1;
	logic          neg_s1;
	hue_sector_t   sector_s1;

	// stage 2: dividends
	logic [SN_W-1:0] sat_num_s2;
	logic [HN_W-1:0] hue_num_s2;
	logic [CB-1:0]   mx_s2, delta_s2;
	logic            neg_s2, def_s2;
	hue_sector_t     sector_s2;

	// sideband through the divider stages
	logic [CB-1:0] mx_sd     [DIV_STAGES];
	logic          neg_sd    [DIV_STAGES];
	logic          def_sd    [DIV_STAGES];
	hue_sector_t   sector_sd [DIV_STAGES];

	// divider results
	logic [SN_W-1:0] sat_quo;
	logic [CB-1:0]   sat_rem;
	logic [HN_W-1:0] hue_quo;
	logic [CB-1:0]   hue_rem;

	// final stage
	logic [HUE_W-1:0] hue_sf;
	logic             def_sf;
	logic [SB-1:0]    sat_sf;
	logic [CB-1:0]    val_sf;

	// ready chain, back to front
	always_comb begin
		adv[NSTG-1] = !vld_q[NSTG-1] || hsv.ready;
		for (int k = NSTG - 2; k >= 0; k--) begin
			adv[k] = !vld_q[k] || adv[k+1];
		end
	end

	assign pix.ready = adv[0];

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (adv[0]) begin
				vld_q[0] <= pix.valid;
			end
			for (int k = 1; k < NSTG; k++) begin
				if (adv[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	// stage 1 logic: pick the largest channel, red then green then blue
	logic [CB-1:0] r_c, g_c, b_c, mx_c, mn_c, da_c, db_c;
	hue_sector_t   sector_c;

	always_comb begin
		r_c = pix.red_in;
		g_c = pix.green_in;
		b_c = pix.blue_in;
		if (r_c >= g_c && r_c >= b_c) begin
			sector_c = SECTOR_RED;
			mx_c     = r_c;
			da_c     = g_c;
			db_c     = b_c;
		end else if (g_c >= b_c) begin
			sector_c = SECTOR_GREEN;
			mx_c     = g_c;
			da_c     = b_c;
			db_c     = r_c;
		end else begin
			sector_c = SECTOR_BLUE;
			mx_c     = b_c;
			da_c     = r_c;
			db_c     = g_c;
		end
		mn_c = (r_c < g_c) ? r_c : g_c;
		mn_c = (mn_c < b_c) ? mn_c : b_c;
	end

	always_ff @(posedge clk) begin
		if (adv[0]) begin
			mx_s1     <= mx_c;
			delta_s1  <= mx_c - mn_c;
			sector_s1 <= sector_c;
			neg_s1    <= da_c < db_c;
			absd_s1   <= (da_c < db_c) ? (db_c - da_c) : (da_c - db_c);
		end
	end

	// stage 2: delta * full scale and |diff| * units per sector
	always_ff @(posedge clk) begin
		if (adv[1]) begin
			sat_num_s2 <= (SN_W'(delta_s1) << SB) - SN_W'(delta_s1);
			hue_num_s2 <= HN_W'(absd_s1) * HN_W'(HUE_UNIT);
			mx_s2      <= mx_s1;
			delta_s2   <= delta_s1;
			neg_s2     <= neg_s1;
			def_s2     <= delta_s1 != '0;
			sector_s2  <= sector_s1;
		end
	end

	// dividers
	rgbhsv_div_pipe #(
		.NUM_W  (SN_W),
		.DEN_W  (CB),
		.STAGES (DIV_STAGES)
	) u_sat_div (
		.clk (clk),
		.en  (adv[LAST_DIV:2]),
		.num (sat_num_s2),
		.den (mx_s2),
		.quo (sat_quo),
		.rem (sat_rem)
	);

	rgbhsv_div_pipe #(
		.NUM_W  (HN_W),
		.DEN_W  (CB),
		.STAGES (DIV_STAGES)
	) u_hue_div (
		.clk (clk),
		.en  (adv[LAST_DIV:2]),
		.num (hue_num_s2),
		.den (delta_s2),
		.quo (hue_quo),
		.rem (hue_rem)
	);

	// sideband alongside the dividers
	always_ff @(posedge clk) begin
		if (adv[2]) begin
			mx_sd[0]     <= mx_s2;
			neg_sd[0]    <= neg_s2;
			def_sd[0]    <= def_s2;
			sector_sd[0] <= sector_s2;
		end
		for (int k = 1; k < DIV_STAGES; k++) begin
			if (adv[k+2]) begin
				mx_sd[k]     <= mx_sd[k-1];
				neg_sd[k]    <= neg_sd[k-1];
				def_sd[k]    <= def_sd[k-1];
				sector_sd[k] <= sector_sd[k-1];
			end
		end
	end

	// final hue: sector base plus or minus the fraction, floored as a whole, wrapped
	logic [HUE_W-1:0] base_c, q_c, t_c, hue_c;
	logic             sat_unused_c;

	always_comb begin
		case (sector_sd[DIV_STAGES-1])
			SECTOR_RED:   base_c = '0;
			SECTOR_GREEN: base_c = HUE_W'(2 * HUE_UNIT);
			SECTOR_BLUE:  base_c = HUE_W'(4 * HUE_UNIT);
			default:      base_c = '0;
		endcase
		q_c = HUE_W'(hue_quo[QH_W-1:0]);
		t_c = q_c + HUE_W'(hue_rem != '0);
		if (!def_sd[DIV_STAGES-1]) begin
			hue_c = '0;
		end else if (!neg_sd[DIV_STAGES-1]) begin
			hue_c = base_c + q_c;
		end else if (sector_sd[DIV_STAGES-1] == SECTOR_RED) begin
			hue_c = HUE_W'(HUE_FULL) - t_c;
		end else begin
			hue_c = base_c - t_c;
		end
		// saturation remainder only matters for rounding, which is floor
		sat_unused_c = ^sat_rem;
	end

	always_ff @(posedge clk) begin
		if (adv[NSTG-1]) begin
			hue_sf <= hue_c;
			def_sf <= def_sd[DIV_STAGES-1];
			sat_sf <= (mx_sd[DIV_STAGES-1] == '0) ? '0 :
				(sat_quo[SB-1:0] | {SB{1'b0 & sat_unused_c}});
			val_sf <= mx_sd[DIV_STAGES-1];
		end
	end

	// result word
	assign hsv.valid          = vld_q[NSTG-1];
	assign hsv.hue_out        = hue_sf;
	assign hsv.hue_defined    = def_sf;
	assign hsv.saturation_out = sat_sf;
	assign hsv.value_out      = val_sf;

endmodule

/* src/rgbhsv_div_pipe.sv */
// ----------------------------------------------------------------------------
// rgbhsv_div_pipe
// Pipelined restoring divider: a fixed number of quotient bits per stage,
// each stage register loads when its enable is high.
// ----------------------------------------------------------------------------
module rgbhsv_div_pipe import rgbhsv_pkg::*; #(
	parameter int NUM_W  = 24,
	parameter int DEN_W  = 8,
	parameter int STAGES = 4
) (
	input  logic              clk,
	input  logic [STAGES-1:0] en,
	input  logic [NUM_W-1:0]  num,
	input  logic [DEN_W-1:0]  den,
	output logic [NUM_W-1:0]  quo,
	output logic [DEN_W-1:0]  rem
);

	localparam int STEPS = (NUM_W + STAGES - 1) / STAGES;
	localparam int PAD_W = STEPS * STAGES;

	// per stage: partial remainder, dividend bits shifting out / quotient in
	logic [DEN_W-1:0] rem_sd [STAGES];
	logic [PAD_W-1:0] nq_sd  [STAGES];
	logic [DEN_W-1:0] den_sd [STAGES];

	genvar k;
	generate
		for (k = 0; k < STAGES; k++) begin : g_stage
			logic [DEN_W-1:0] rem_i;
			logic [PAD_W-1:0] nq_i;
			logic [DEN_W-1:0] den_i;
			logic [DEN_W-1:0] rem_o;
			logic [PAD_W-1:0] nq_o;

			// stage input select
			if (k == 0) begin : g_first
				assign rem_i = '0;
				assign nq_i  = PAD_W'(num);
				assign den_i = den;
			end else begin : g_next
				assign rem_i = rem_sd[k-1];
				assign nq_i  = nq_sd[k-1];
				assign den_i = den_sd[k-1];
			end

			// shift-subtract steps of this stage
			always_comb begin
				logic [DEN_W:0]   trial;
				logic [DEN_W-1:0] r;
				logic [PAD_W-1:0] x;
				r = rem_i;
				x = nq_i;
				for (int i = 0; i < STEPS; i++) begin
					trial = {r, x[PAD_W-1]};
					x = x << 1;
					if (trial >= {1'b0, den_i}) begin
						trial = trial - {1'b0, den_i};
						x[0] = 1'b1;
					end
					r = trial[DEN_W-1:0];
				end
				rem_o = r;
				nq_o  = x;
			end

			// stage register
			always_ff @(posedge clk) begin
				if (en[k]) begin
					rem_sd[k] <= rem_o;
					nq_sd[k]  <= nq_o;
					den_sd[k] <= den_i;
				end
			end
		end
	endgenerate

	assign quo = nq_sd[STAGES-1][NUM_W-1:0];
	assign rem = rem_sd[STAGES-1];

endmodule

/* src/rgbhsv_checker.sv */
// ----------------------------------------------------------------------------
// rgbhsv_checker
// Port-level checks on the hsv result stream of the converter.
// ----------------------------------------------------------------------------
module rgbhsv_checker import rgbhsv_pkg::*; #(
	parameter int CHANNEL_BITS      = 8,
	parameter int HUE_FRACTION_BITS = 6,
	parameter int SATURATION_BITS   = 16
) (
	input logic                                   clk,
	input logic                                   arst_n,
	input logic                                   hsv_valid,
	input logic                                   hsv_ready,
	input logic [hue_width(HUE_FRACTION_BITS)-1:0] hue_out,
	input logic                                   hue_defined,
	input logic [SATURATION_BITS-1:0]             saturation_out,
	input logic [CHANNEL_BITS-1:0]                value_out
);

	localparam int HUE_W    = hue_width(HUE_FRACTION_BITS);
	localparam int HUE_FULL = HUE_CIRCLE * (2 ** HUE_FRACTION_BITS);

	// a stalled result word holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		hsv_valid && !hsv_ready |=> hsv_valid && $stable(hue_out) &&
		$stable(hue_defined) && $stable(saturation_out) && $stable(value_out))
		else $error("result word changed while stalled");

	// hue stays inside one circle
	a_hue_range: assert property (@(posedge clk) disable iff (!arst_n)
		hsv_valid |-> hue_out < HUE_W'(HUE_FULL))
		else $error("hue out of range");

	// undefined hue reads as zero
	a_hue_zero: assert property (@(posedge clk) disable iff (!arst_n)
		hsv_valid && !hue_defined |-> hue_out == '0)
		else $error("undefined hue is not zero");

	// black has no saturation and no hue
	a_black: assert property (@(posedge clk) disable iff (!arst_n)
		hsv_valid && value_out == '0 |-> saturation_out == '0 && !hue_defined)
		else $error("black pixel with saturation or hue");

endmodule

bind rgb_to_hsv_converter rgbhsv_checker #(
	.CHANNEL_BITS      (CHANNEL_BITS),
	.HUE_FRACTION_BITS (HUE_FRACTION_BITS),
	.SATURATION_BITS   (SATURATION_BITS)
) u_rgbhsv_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.hsv_valid      (hsv.valid),
	.hsv_ready      (hsv.ready),
	.hue_out        (hsv.hue_out),
	.hue_defined    (hsv.hue_defined),
	.saturation_out (hsv.saturation_out),
	.value_out      (hsv.value_out)
);
